FILE: rtl/bhp_pkg.sv
// ---------------------------------------------------------------------------
// bhp_pkg
// Types, field positions and constants shared by the BMP header parser.
// ---------------------------------------------------------------------------
package bhp_pkg;

   // byte stream word
   typedef struct packed {
      logic [7:0] byte_value;
      logic       first_byte;
      logic       end_of_file;
   } bhp_req_type;

   // parse result word
   typedef struct packed {
      logic               status;
      logic signed [31:0] image_width;
      logic [31:0]        image_height;
      logic [3:0]         component_bits;
      logic [1:0]         component_count;
      logic [42:0]        horiz_dpi_q16;
      logic [42:0]        vert_dpi_q16;
   } bhp_rsp_type;

   localparam int BHP_MAX_HEADER_BYTES = 138;

   // status codes
   localparam logic BHP_STATUS_OK    = 1'b0;
   localparam logic BHP_STATUS_ERROR = 1'b1;

   // signature and header sizes
   localparam logic [7:0]  BHP_CHAR_B        = 8'h42;
   localparam logic [7:0]  BHP_CHAR_M        = 8'h4D;
   localparam logic [31:0] BHP_FILE_HDR      = 32'd14;
   localparam logic [31:0] BHP_CORE_HDR      = 32'd12;
   localparam logic [31:0] BHP_INFO_HDR      = 32'd40;
   localparam logic [31:0] BHP_INFO_V3_HDR   = 32'd64;
   localparam logic [31:0] BHP_INFO_V4_HDR   = 32'd108;
   localparam logic [31:0] BHP_INFO_V5_HDR   = 32'd124;
   localparam logic [2:0]  BHP_CORE_ENTRY    = 3'd3;
   localparam logic [2:0]  BHP_INFO_ENTRY    = 3'd4;
   localparam logic [15:0] BHP_BITS_TRUE     = 16'd24;

   // byte positions in the file
   localparam logic [7:0] BHP_POS_SIG_M      = 8'd1;
   localparam logic [7:0] BHP_POS_RESERVED   = 8'd6;
   localparam logic [7:0] BHP_POS_OFFSET     = 8'd10;
   localparam logic [7:0] BHP_POS_HDR_LEN    = 8'd14;
   localparam logic [7:0] BHP_POS_WIDTH      = 8'd18;
   localparam logic [7:0] BHP_POS_CORE_HGT   = 8'd20;
   localparam logic [7:0] BHP_POS_CORE_PLN   = 8'd22;
   localparam logic [7:0] BHP_POS_CORE_BITS  = 8'd24;
   localparam logic [7:0] BHP_POS_INFO_HGT   = 8'd22;
   localparam logic [7:0] BHP_POS_INFO_PLN   = 8'd26;
   localparam logic [7:0] BHP_POS_INFO_BITS  = 8'd28;
   localparam logic [7:0] BHP_POS_INFO_SKIP  = 8'd30;
   localparam logic [7:0] BHP_POS_HORIZ_PPM  = 8'd38;
   localparam logic [7:0] BHP_POS_VERT_PPM   = 8'd42;
   localparam logic [7:0] BHP_POS_PPM_END    = 8'd46;
   localparam logic [7:0] BHP_POS_LAST       = 8'd255;

   // dpi conversion: ppm * 127 * 65536 / 5000, rounded half up
   localparam logic [42:0] BHP_DPI_72_Q16    = 43'd4718592;
   localparam logic [46:0] BHP_ROUND_HALF    = 47'd2500;
   localparam logic [23:0] BHP_RECIP_5000    = 24'd13743896;
   localparam int          BHP_RECIP_SHIFT   = 36;

   // byte b in lane k contributes b * 5000 * quot(k) + b * rem(k)
   function automatic logic [34:0] bhp_lane_quot(input logic [1:0] lane);
      logic [34:0] q;
      unique case (lane)
         2'd0:    q = 35'd1664;
         2'd1:    q = 35'd426141;
         2'd2:    q = 35'd109092169;
         default: q = 35'd27927595345;
      endcase
      return q;
   endfunction

   function automatic logic [11:0] bhp_lane_rem(input logic [1:0] lane);
      logic [11:0] r;
      unique case (lane)
         2'd0:    r = 12'd3072;
         2'd1:    r = 12'd1432;
         2'd2:    r = 12'd1592;
         default: r = 12'd2552;
      endcase
      return r;
   endfunction

   // little-endian byte insert
   function automatic logic [31:0] bhp_put_lane32(input logic [31:0] acc,
                                                  input logic [1:0]  lane,
                                                  input logic [7:0]  b);
      logic [31:0] r;
      r = acc;
      r[lane*8 +: 8] = b;
      return r;
   endfunction

   function automatic logic [15:0] bhp_put_lane16(input logic [15:0] acc,
                                                  input logic        lane,
                                                  input logic [7:0]  b);
      logic [15:0] r;
      r = acc;
      r[lane*8 +: 8] = b;
      return r;
   endfunction

endpackage

FILE: rtl/bmp_header_parser_core.sv
// ---------------------------------------------------------------------------
// bmp_header_parser_core
// Parses the file and DIB headers of a BMP byte stream into image geometry.
// ---------------------------------------------------------------------------
// Takes one file byte per word on the req channel, one word per clock while
// the rsp side is not stalled, and returns at most one result word per file
// on the rsp channel: status 0 with width, absolute height, component format
// and Q.16 DPI once the last header byte is seen, or status 1 as soon as a
// check fails or end_of_file cuts the header short. A byte goes through the
// input register, then the single-pass byte decode into the result register;
// a stalled rsp side holds the req side through the result register. Bytes
// after a result are dropped until the next first_byte word, which restarts
// the parse at any time. DPI is built up exactly as quotient and remainder
// while the resolution bytes arrive, so the final rounding is one small multiply.
module bmp_header_parser_core #(
   parameter int MAX_HEADER_BYTES = bhp_pkg::BHP_MAX_HEADER_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bhp_pkg::bhp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bhp_pkg::bhp_rsp_type rsp_data
);
   import bhp_pkg::*;

   // pipeline registers
   logic        s1_valid_ff, s1_valid_in;
   bhp_req_type s1_data_ff,  s1_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bhp_rsp_type rsp_data_ff,  rsp_data_in;

   // parse state
   logic [7:0]  byte_index_ff, byte_index_in;
   logic        finished_ff,   finished_in;
   logic [31:0] offset_ff,     offset_in;
   logic [31:0] hdr_len_ff,    hdr_len_in;
   logic [31:0] width_ff,      width_in;
   logic [31:0] height_ff,     height_in;
   logic [15:0] planes_ff,     planes_in;
   logic [15:0] bits_ff,       bits_in;
   logic [42:0] hq_ff,         hq_in;
   logic [22:0] hr_ff,         hr_in;
   logic [42:0] vq_ff,         vq_in;
   logic [22:0] vr_ff,         vr_in;

   logic        advance;
   logic        first;
   logic        active;
   logic        is_core;
   logic        fail;
   logic        done;
   logic        emit;
   logic [7:0]  b;
   logic [7:0]  idx;
   logic [1:0]  lane;
   logic [31:0] abs_height;
   logic [46:0] h_round;
   logic [46:0] v_round;
   logic [42:0] h_dpi;
   logic [42:0] v_dpi;

   function automatic logic hdr_ok(input logic [31:0] hs);
      logic known;
      known = (hs == BHP_CORE_HDR) || (hs == BHP_INFO_HDR) || (hs == BHP_INFO_V3_HDR)
           || (hs == BHP_INFO_V4_HDR) || (hs == BHP_INFO_V5_HDR);
      return known && (({1'b0, hs} + {1'b0, BHP_FILE_HDR}) <= 33'(MAX_HEADER_BYTES));
   endfunction

   // palette formats need room for at least one entry before the pixels
   function automatic logic bits_ok(input logic [15:0] bc, input logic [31:0] ofs,
                                    input logic [31:0] hl, input logic [2:0] entry);
      logic ok;
      if (bc == BHP_BITS_TRUE) begin
         ok = 1'b1;
      end else if (bc != 16'd1 && bc != 16'd4 && bc != 16'd8) begin
         ok = 1'b0;
      end else begin
         ok = {1'b0, ofs} >= ({1'b0, hl} + {1'b0, BHP_FILE_HDR} + {30'd0, entry});
      end
      return ok;
   endfunction

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   // dpi rounding from the quotient and remainder sums
   always_comb begin
      h_round    = ({24'd0, hr_ff} + BHP_ROUND_HALF) * {23'd0, BHP_RECIP_5000};
      v_round    = ({24'd0, vr_ff} + BHP_ROUND_HALF) * {23'd0, BHP_RECIP_5000};
      h_dpi      = hq_ff + {32'd0, h_round[46:BHP_RECIP_SHIFT]};
      v_dpi      = vq_ff + {32'd0, v_round[46:BHP_RECIP_SHIFT]};
   end

   // byte decode
   always_comb begin
      first = s1_data_ff.first_byte;
      b     = s1_data_ff.byte_value;
      active = first || !finished_ff;
      idx   = first ? 8'd0 : byte_index_ff;

      offset_in = first ? '0 : offset_ff;
      hdr_len_in = first ? '0 : hdr_len_ff;
      width_in  = first ? '0 : width_ff;
      height_in = first ? '0 : height_ff;
      planes_in = first ? '0 : planes_ff;
      bits_in   = first ? '0 : bits_ff;
      hq_in     = first ? '0 : hq_ff;
      hr_in     = first ? '0 : hr_ff;
      vq_in     = first ? '0 : vq_ff;
      vr_in     = first ? '0 : vr_ff;

      is_core = (hdr_len_in == BHP_CORE_HDR);
      lane    = 2'd0;
      fail    = 1'b0;
      done    = 1'b0;

      priority if (idx == 8'd0) begin
         fail = (b != BHP_CHAR_B);
      end else if (idx == BHP_POS_SIG_M) begin
         fail = (b != BHP_CHAR_M);
      end else if (idx < BHP_POS_RESERVED) begin
         fail = 1'b0;
      end else if (idx < BHP_POS_OFFSET) begin
         fail = (b != 8'd0);
      end else if (idx < BHP_POS_HDR_LEN) begin
         offset_in = bhp_put_lane32(offset_in, 2'(idx - BHP_POS_OFFSET), b);
      end else if (idx < BHP_POS_WIDTH) begin
         hdr_len_in = bhp_put_lane32(hdr_len_in, 2'(idx - BHP_POS_HDR_LEN), b);
         fail = (idx == BHP_POS_WIDTH - 8'd1) && !hdr_ok(hdr_len_in);
      end else if (is_core) begin
         // core header: 16-bit width and height
         priority if (idx < BHP_POS_CORE_HGT) begin
            width_in = bhp_put_lane32(width_in, 2'(idx - BHP_POS_WIDTH), b);
            fail = (idx == BHP_POS_CORE_HGT - 8'd1) && (width_in == 32'd0);
         end else if (idx < BHP_POS_CORE_PLN) begin
            height_in = bhp_put_lane32(height_in, 2'(idx - BHP_POS_CORE_HGT), b);
            fail = (idx == BHP_POS_CORE_PLN - 8'd1) && (height_in == 32'd0);
         end else if (idx < BHP_POS_CORE_BITS) begin
            planes_in = bhp_put_lane16(planes_in, 1'(idx - BHP_POS_CORE_PLN), b);
            fail = (idx == BHP_POS_CORE_BITS - 8'd1) && (planes_in != 16'd1);
         end else begin
            bits_in = bhp_put_lane16(bits_in, 1'(idx - BHP_POS_CORE_BITS), b);
            if (idx == BHP_POS_CORE_BITS + 8'd1) begin
               fail = !bits_ok(bits_in, offset_in, hdr_len_in, BHP_CORE_ENTRY);
               done = !fail;
            end
         end
      end else begin
         // info headers: 32-bit width and height, resolution fields
         priority if (idx < BHP_POS_INFO_HGT) begin
            width_in = bhp_put_lane32(width_in, 2'(idx - BHP_POS_WIDTH), b);
            fail = (idx == BHP_POS_INFO_HGT - 8'd1) && (width_in == 32'd0);
         end else if (idx < BHP_POS_INFO_PLN) begin
            height_in = bhp_put_lane32(height_in, 2'(idx - BHP_POS_INFO_HGT), b);
            fail = (idx == BHP_POS_INFO_PLN - 8'd1) && (height_in == 32'd0);
         end else if (idx < BHP_POS_INFO_BITS) begin
            planes_in = bhp_put_lane16(planes_in, 1'(idx - BHP_POS_INFO_PLN), b);
            fail = (idx == BHP_POS_INFO_BITS - 8'd1) && (planes_in != 16'd1);
         end else if (idx < BHP_POS_INFO_SKIP) begin
            bits_in = bhp_put_lane16(bits_in, 1'(idx - BHP_POS_INFO_BITS), b);
            fail = (idx == BHP_POS_INFO_SKIP - 8'd1)
                && !bits_ok(bits_in, offset_in, hdr_len_in, BHP_INFO_ENTRY);
         end else begin
            if (idx >= BHP_POS_HORIZ_PPM && idx < BHP_POS_VERT_PPM) begin
               lane  = 2'(idx - BHP_POS_HORIZ_PPM);
               hq_in = hq_in + ({35'd0, b} * {8'd0, bhp_lane_quot(lane)});
               hr_in = hr_in + ({15'd0, b} * {11'd0, bhp_lane_rem(lane)});
            end else if (idx >= BHP_POS_VERT_PPM && idx < BHP_POS_PPM_END) begin
               lane  = 2'(idx - BHP_POS_VERT_PPM);
               vq_in = vq_in + ({35'd0, b} * {8'd0, bhp_lane_quot(lane)});
               vr_in = vr_in + ({15'd0, b} * {11'd0, bhp_lane_rem(lane)});
            end
            done = ({24'd0, idx} == hdr_len_in + BHP_FILE_HDR - 32'd1);
         end
      end

      emit = active && (fail || done || s1_data_ff.end_of_file);
      byte_index_in = (idx == BHP_POS_LAST) ? idx : idx + 8'd1;
      finished_in   = emit;
   end

   // result word
   always_comb begin
      abs_height = height_ff[31] ? (32'd0 - height_ff) : height_ff;

      rsp_data_in = '0;
      rsp_data_in.status = BHP_STATUS_ERROR;
      if (done && !fail) begin
         rsp_data_in.status          = BHP_STATUS_OK;
         rsp_data_in.image_width     = width_ff;
         rsp_data_in.image_height    = is_core ? abs_height
                                     : (height_in[31] ? (32'd0 - height_in) : height_in);
         rsp_data_in.component_bits  = (bits_in == BHP_BITS_TRUE) ? 4'd8 : bits_in[3:0];
         rsp_data_in.component_count = (bits_in == BHP_BITS_TRUE) ? 2'd3 : 2'd1;
         rsp_data_in.horiz_dpi_q16   = is_core ? BHP_DPI_72_Q16 : h_dpi;
         rsp_data_in.vert_dpi_q16    = is_core ? BHP_DPI_72_Q16 : v_dpi;
         if (is_core) begin
            rsp_data_in.image_width = width_ff;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= '0;
         finished_ff   <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && active) begin
            byte_index_ff <= byte_index_in;
            finished_ff   <= finished_in;
         end
      end
   end

   // payload and field registers
   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      if (advance && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (advance && active) begin
         offset_ff  <= offset_in;
         hdr_len_ff <= hdr_len_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         planes_ff  <= planes_in;
         bits_ff    <= bits_in;
         hq_ff      <= hq_in;
         hr_ff      <= hr_in;
         vq_ff      <= vq_in;
         vr_ff      <= vr_in;
      end
   end

endmodule
